FILE: hw/rtl/agrs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types, activation tables and lookup helpers for the gated recurrence step.
package agrs_pkg;

	localparam int DEPTH      = 1024;
	localparam int FRAC_BITS  = 12;
	localparam int TABLE_SIZE = 256;

	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int UNIT_W  = 10;
	localparam int DATA_W  = 16;
	localparam int ALPHA_W = 13;
	localparam int OUT_W   = 15;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 64;

	localparam int ENT_W = FRAC_BITS + 2;
	localparam int IDX_W = $clog2(TABLE_SIZE + 1);
	localparam int FR_W  = FRAC_BITS + 4;
	localparam int POS_W = FRAC_BITS + 5;
	localparam int P_W   = POS_W + $clog2(TABLE_SIZE) + 1;
	localparam int K_W   = P_W - FR_W;
	localparam int PROD_W = 48;

	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam longint unsigned Q30 = longint'(1) << 30;
	localparam longint unsigned INV_E_Q30 = 395007542;

	localparam logic [0:0] REQ_LOAD = 1'b0;
	localparam logic [0:0] REQ_STEP = 1'b1;

	typedef logic signed [ENT_W-1:0] tab_t [TABLE_SIZE+1];

	typedef struct packed {
		logic [IDX_W-1:0] k;
		logic [IDX_W-1:0] k1;
		logic [FR_W-1:0]  r;
	} pos_t;

	typedef struct packed {
		logic              busy;
		logic              we;
		logic [ADDR_W-1:0] addr;
	} clr_t;

	// restoring divide, only used while building the constant tables
	function automatic longint unsigned udiv(input longint unsigned a,
		input longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned exp_neg(input longint unsigned t);
		longint unsigned n;
		longint unsigned f;
		longint unsigned term;
		longint sum;
		n = t >> 30;
		f = t & (Q30 - 1);
		term = Q30;
		sum = longint'(Q30);
		for (int i = 1; i <= 16; i++) begin
			term = udiv((term * f) >> 30, 64'(i));
			if (i[0]) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (n > 40) return 0;
		for (longint j = 0; j < longint'(n); j++) begin
			sum = longint'((longint'(unsigned'(sum)) * INV_E_Q30 + (Q30 >> 1)) >> 30);
		end
		return longint'(unsigned'(sum));
	endfunction

	function automatic tab_t build_tab(input logic is_tanh);
		tab_t tab;
		longint d;
		logic neg;
		longint unsigned m;
		longint unsigned e;
		longint unsigned den;
		longint unsigned s;
		for (int k = 0; k <= TABLE_SIZE; k++) begin
			d = 16 * longint'(k) - 8 * longint'(TABLE_SIZE);
			neg = d < 0;
			m = udiv(unsigned'((neg ? -d : d) << 30), 64'(TABLE_SIZE));
			if (!is_tanh) begin
				e = exp_neg(m);
				den = Q30 + e;
				if (neg) s = udiv((e << FRAC_BITS) + (den >> 1), den);
				else s = udiv((longint'(ONE) << 30) + (den >> 1), den);
				tab[k] = ENT_W'(s);
			end else begin
				e = exp_neg(2 * m);
				den = Q30 + e;
				s = udiv(((Q30 - e) << FRAC_BITS) + (den >> 1), den);
				tab[k] = neg ? -ENT_W'(s) : ENT_W'(s);
			end
		end
		return tab;
	endfunction

	localparam tab_t SIG_TAB  = build_tab(1'b0);
	localparam tab_t TANH_TAB = build_tab(1'b1);

	function automatic pos_t lut_pos(input logic signed [DATA_W-1:0] x);
		logic signed [POS_W:0] xc;
		logic signed [POS_W:0] eight;
		logic [POS_W-1:0] u;
		logic [P_W-1:0] p;
		logic [K_W-1:0] k;
		pos_t res;
		eight = (POS_W+1)'(8 * ONE);
		xc = (POS_W+1)'(x);
		if (xc > eight) xc = eight;
		if (xc < -eight) xc = -eight;
		u = POS_W'(xc + eight);
		p = P_W'(u) * P_W'(TABLE_SIZE);
		k = p[P_W-1:FR_W];
		res.r = p[FR_W-1:0];
		if (k >= K_W'(TABLE_SIZE)) begin
			res.k  = IDX_W'(TABLE_SIZE);
			res.k1 = IDX_W'(TABLE_SIZE);
		end else begin
			res.k  = IDX_W'(k);
			res.k1 = IDX_W'(k + 1'b1);
		end
		return res;
	endfunction

	function automatic logic signed [ENT_W-1:0] interp(input logic signed [ENT_W-1:0] tk,
		input logic signed [ENT_W-1:0] tk1, input logic [FR_W-1:0] r);
		logic signed [ENT_W+FR_W+1:0] d;
		logic signed [ENT_W+FR_W+1:0] rr;
		logic signed [ENT_W+FR_W+1:0] pr;
		logic signed [ENT_W+FR_W+1:0] half;
		logic signed [ENT_W+FR_W+1:0] c;
		d = (ENT_W+FR_W+2)'(tk1) - (ENT_W+FR_W+2)'(tk);
		rr = $signed({{(ENT_W+2){1'b0}}, r});
		pr = d * rr;
		half = (ENT_W+FR_W+2)'(1) <<< (FR_W - 1);
		if (pr >= 0) c = (pr + half) >>> FR_W;
		else c = -((-pr + half) >>> FR_W);
		return ENT_W'((ENT_W+FR_W+2)'(tk) + c);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
		if (v > PROD_W'(32767)) return DATA_W'(32767);
		if (v < -PROD_W'(32768)) return DATA_W'(-32768);
		return DATA_W'(v);
	endfunction

endpackage

FILE: hw/rtl/agrs_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module agrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/agrs_clear.sv
`timescale 1ns / 1ps
// Post-reset sweep that zeroes the hidden-state memory one entry per cycle.
module agrs_clear (
	input  logic                 clk,
	input  logic                 arst_n,
	output agrs_pkg::clr_t       ctl
);

	logic                        busy_q;
	logic [agrs_pkg::ADDR_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == agrs_pkg::ADDR_W'(agrs_pkg::DEPTH - 1)) busy_q <= 1'b0;
		end
	end

	always_comb begin
		ctl.busy = busy_q;
		ctl.we   = busy_q;
		ctl.addr = cnt_q;
	end

endmodule

FILE: hw/rtl/additive_gated_recurrence_step.sv
`timescale 1ns / 1ps
// Top level: hidden-state memory, nine-stage update pipeline and output register.
// Path: a step word runs through stages 1-9 and the output register; loads give no word.
// Throughput: one word per cycle unless m_tready holds the output; a word whose unit
// matches one still in stages 1-6 (before its memory write-back) waits for that write.
// Reset: arst_n clears control; then a sweep zeroes the whole memory, s_tready low.
module additive_gated_recurrence_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // unit_index, gate_pre, proj_in, init_value, zero pad
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // hidden_new, out_value, value_pre, gate_alpha, zero pad
);

	localparam int DW = agrs_pkg::DATA_W;
	localparam int EW = agrs_pkg::ENT_W;
	localparam int UW = agrs_pkg::UNIT_W;
	localparam int F  = agrs_pkg::FRAC_BITS;
	localparam int PW = agrs_pkg::PROD_W;

	agrs_pkg::clr_t clr;

	logic [UW-1:0]        in_idx;
	logic signed [DW-1:0] in_gate, in_proj, in_init;
	logic                 in_acc, adv, hazard;

	logic                 v1, st1, ok1;
	logic [UW-1:0]        idx1;
	logic signed [DW-1:0] gate1, proj1, init1;
	logic                 v2, st2, ok2;
	logic [UW-1:0]        idx2;
	logic signed [DW-1:0] init2, h2, vp2;
	logic signed [EW-1:0] gk2, gk12;
	logic [agrs_pkg::FR_W-1:0] gr2;
	logic                 v3, st3, ok3;
	logic [UW-1:0]        idx3;
	logic signed [DW-1:0] init3, h3, vp3;
	logic signed [EW-1:0] alpha3, tk3, tk13;
	logic [agrs_pkg::FR_W-1:0] tr3;
	logic                 v4, st4, ok4;
	logic [UW-1:0]        idx4;
	logic signed [DW-1:0] init4, h4, vp4;
	logic signed [EW-1:0] alpha4, tv4;
	logic                 v5, st5, ok5;
	logic [UW-1:0]        idx5;
	logic signed [DW-1:0] init5, vp5;
	logic signed [EW-1:0] alpha5;
	logic signed [31:0]   m1_5, m2_5;
	logic                 v6, st6, ok6;
	logic [UW-1:0]        idx6;
	logic signed [DW-1:0] init6, vp6, hn6;
	logic signed [EW-1:0] alpha6;
	logic                 v7;
	logic signed [DW-1:0] vp7, hn7;
	logic signed [EW-1:0] alpha7, sk7, sk17;
	logic [agrs_pkg::FR_W-1:0] sr7;
	logic                 v8;
	logic signed [DW-1:0] vp8, hn8;
	logic signed [EW-1:0] alpha8, sh8;
	logic [31:0]          sq8;
	logic                 v9;
	logic signed [DW-1:0] vp9, hn9;
	logic signed [EW-1:0] alpha9;
	logic [PW-1:0]        prod9;

	logic                 m_tvalid_q;
	logic [63:0]          m_tdata_q;

	logic [DW-1:0]        rdata;
	logic signed [DW-1:0] h1;
	logic                 ram_we;
	logic [agrs_pkg::ADDR_W-1:0] ram_waddr;
	logic [DW-1:0]        ram_wdata;

	agrs_pkg::pos_t       gpos, vpos, hpos;
	logic signed [DW-1:0] vp_c, hn_c;
	logic signed [EW-1:0] onem;
	logic signed [31:0]   m1_c, m2_c, sq_c;
	logic signed [PW-1:0] mix, half_f, rnd;
	logic [PW-1:0]        o_sum;
	logic [agrs_pkg::OUT_W-1:0]   o_c;
	logic [agrs_pkg::ALPHA_W-1:0] a_c;

	assign in_idx  = s_tdata[9:0];
	assign in_gate = s_tdata[25:10];
	assign in_proj = s_tdata[41:26];
	assign in_init = s_tdata[57:42];

	assign adv    = !(v9 && m_tvalid_q && !m_tready);
	assign hazard = (v1 && idx1 == in_idx) || (v2 && idx2 == in_idx) ||
		(v3 && idx3 == in_idx) || (v4 && idx4 == in_idx) ||
		(v5 && idx5 == in_idx) || (v6 && idx6 == in_idx);
	assign s_tready = adv && !clr.busy && !hazard;
	assign in_acc   = s_tvalid && s_tready;

	agrs_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (clr)
	);

	assign ram_we    = clr.we || (v6 && ok6 && adv);
	assign ram_waddr = clr.busy ? clr.addr : idx6[agrs_pkg::ADDR_W-1:0];
	assign ram_wdata = clr.busy ? '0 : ((st6 == agrs_pkg::REQ_STEP) ? hn6 : init6);

	agrs_ram #(
		.WIDTH (DW),
		.DEPTH (agrs_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (adv),
		.raddr (in_idx[agrs_pkg::ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		h1   = ok1 ? $signed(rdata) : '0;
		vp_c = agrs_pkg::sat16(PW'(h1) + PW'(proj1));
		gpos = agrs_pkg::lut_pos(gate1);
		vpos = agrs_pkg::lut_pos(vp2);
		onem = EW'(agrs_pkg::ONE) - alpha4;
		m1_c = 32'(alpha4) * 32'(h4);
		m2_c = 32'(onem) * 32'(tv4);
		mix  = PW'(m1_5) + PW'(m2_5);
		half_f = PW'(1) <<< (F - 1);
		if (mix >= 0) rnd = (mix + half_f) >>> F;
		else rnd = -((-mix + half_f) >>> F);
		hn_c = agrs_pkg::sat16(rnd);
		hpos = agrs_pkg::lut_pos(hn6);
		sq_c = 32'(hn7) * 32'(hn7);
		o_sum = (prod9 + (PW'(1) << (3 * F - 1))) >> (3 * F);
		o_c   = (o_sum > PW'(32767)) ? agrs_pkg::OUT_W'(32767) : agrs_pkg::OUT_W'(o_sum);
		a_c   = (alpha9 > EW'(8191)) ? agrs_pkg::ALPHA_W'(8191) : agrs_pkg::ALPHA_W'(alpha9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
			v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
		end else if (adv) begin
			v1 <= in_acc;
			v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
			v7 <= v6 && (st6 == agrs_pkg::REQ_STEP);
			v8 <= v7; v9 <= v8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st1 <= s_tuser; idx1 <= in_idx;
			ok1 <= 32'(in_idx) < agrs_pkg::DEPTH;
			gate1 <= in_gate; proj1 <= in_proj; init1 <= in_init;

			st2 <= st1; ok2 <= ok1; idx2 <= idx1; init2 <= init1;
			h2 <= h1; vp2 <= vp_c;
			gk2 <= agrs_pkg::SIG_TAB[gpos.k]; gk12 <= agrs_pkg::SIG_TAB[gpos.k1]; gr2 <= gpos.r;

			st3 <= st2; ok3 <= ok2; idx3 <= idx2; init3 <= init2;
			h3 <= h2; vp3 <= vp2;
			alpha3 <= agrs_pkg::interp(gk2, gk12, gr2);
			tk3 <= agrs_pkg::TANH_TAB[vpos.k]; tk13 <= agrs_pkg::TANH_TAB[vpos.k1]; tr3 <= vpos.r;

			st4 <= st3; ok4 <= ok3; idx4 <= idx3; init4 <= init3;
			h4 <= h3; vp4 <= vp3; alpha4 <= alpha3;
			tv4 <= agrs_pkg::interp(tk3, tk13, tr3);

			st5 <= st4; ok5 <= ok4; idx5 <= idx4; init5 <= init4;
			vp5 <= vp4; alpha5 <= alpha4; m1_5 <= m1_c; m2_5 <= m2_c;

			st6 <= st5; ok6 <= ok5; idx6 <= idx5; init6 <= init5;
			vp6 <= vp5; alpha6 <= alpha5; hn6 <= hn_c;

			vp7 <= vp6; alpha7 <= alpha6; hn7 <= hn6;
			sk7 <= agrs_pkg::SIG_TAB[hpos.k]; sk17 <= agrs_pkg::SIG_TAB[hpos.k1]; sr7 <= hpos.r;

			vp8 <= vp7; alpha8 <= alpha7; hn8 <= hn7;
			sh8 <= agrs_pkg::interp(sk7, sk17, sr7);
			sq8 <= unsigned'(sq_c);

			vp9 <= vp8; alpha9 <= alpha8; hn9 <= hn8;
			prod9 <= PW'(sq8) * PW'(unsigned'(sh8));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid_q <= 1'b0;
		else if (!m_tvalid_q || m_tready) m_tvalid_q <= v9;
	end

	always_ff @(posedge clk) begin
		if ((!m_tvalid_q || m_tready) && v9)
			m_tdata_q <= {4'b0, a_c, vp9, o_c, hn9};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr.busy |-> !v6) else $error("pipeline write during memory clear");

	a_no_unit_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !(v1 && idx1 == in_idx)) else $error("same unit accepted while in flight");

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(v9)) else $error("output word without a finished step");

endmodule

FILE: tb/agrs_step_checker.sv
`timescale 1ns / 1ps
// Checker for the gated recurrence step: predicts each result word from the inputs and compares it.
module agrs_step_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	output int          errors,
	output int          pending
);

	localparam longint unsigned Q30_U = 64'd1 << 30;
	localparam int TS = agrs_pkg::TABLE_SIZE;
	localparam int FB = agrs_pkg::FRAC_BITS;

	typedef struct {
		logic signed [15:0] hidden_new;
		logic [14:0]        out_value;
		logic signed [15:0] value_pre;
		logic [12:0]        gate_alpha;
	} cell_out_t;

	longint          sig_lut [TS+1];
	longint          tanh_lut [TS+1];
	logic signed [15:0] hidden_mem [agrs_pkg::DEPTH];
	cell_out_t       cell_q [$];

	function automatic longint unsigned decay(input longint unsigned t);
		longint unsigned whole;
		longint unsigned part;
		longint unsigned term;
		longint acc;
		whole = t >> 30;
		part = t & (Q30_U - 1);
		term = Q30_U;
		acc = longint'(Q30_U);
		for (int i = 1; i <= 16; i++) begin
			term = ((term * part) >> 30) / longint'(i);
			if (i % 2 == 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		if (acc < 0) acc = 0;
		if (whole > 40) return 0;
		repeat (whole) acc = longint'((longint'(acc) * 64'd395007542 + (Q30_U >> 1)) >> 30);
		return longint'(acc);
	endfunction

	function automatic longint rnd_shift(input longint v, input int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0) return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint clip16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint act_lookup(input logic is_tanh, input longint x);
		longint one;
		longint unsigned p;
		longint unsigned k;
		longint unsigned r;
		longint t0;
		longint t1;
		one = longint'(1) << FB;
		if (x < -8 * one) x = -8 * one;
		if (x > 8 * one) x = 8 * one;
		p = longint'(x + 8 * one) * TS;
		k = p >> (FB + 4);
		r = p & ((longint'(1) << (FB + 4)) - 1);
		if (k >= TS) return is_tanh ? tanh_lut[TS] : sig_lut[TS];
		t0 = is_tanh ? tanh_lut[k] : sig_lut[k];
		t1 = is_tanh ? tanh_lut[k+1] : sig_lut[k+1];
		return t0 + rnd_shift((t1 - t0) * longint'(r), FB + 4);
	endfunction

	initial begin
		longint d;
		longint unsigned m;
		longint unsigned e;
		longint unsigned den;
		longint unsigned th;
		for (int k = 0; k <= TS; k++) begin
			d = 16 * longint'(k) - 8 * longint'(TS);
			m = ((d < 0 ? -d : d) << 30) / TS;
			e = decay(m);
			den = Q30_U + e;
			if (d < 0) sig_lut[k] = ((e << FB) + den / 2) / den;
			else sig_lut[k] = ((longint'(1) << (30 + FB)) + den / 2) / den;
			e = decay(2 * m);
			den = Q30_U + e;
			th = (((Q30_U - e) << FB) + den / 2) / den;
			tanh_lut[k] = d < 0 ? -longint'(th) : longint'(th);
		end
	end

	assign pending = cell_q.size();

	always @(posedge clk or negedge arst_n) begin
		longint unsigned idx;
		longint h;
		longint alpha;
		longint vp;
		longint v;
		longint hn;
		longint sg;
		longint unsigned o;
		cell_out_t exp_w;
		cell_out_t got;
		if (!arst_n) begin
			foreach (hidden_mem[i]) hidden_mem[i] = '0;
			errors = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				idx = s_tdata[9:0];
				if (s_tuser != agrs_pkg::REQ_STEP) begin
					if (idx < agrs_pkg::DEPTH) hidden_mem[idx] = s_tdata[57:42];
				end else begin
					h = idx < agrs_pkg::DEPTH ? longint'(hidden_mem[idx]) : 0;
					alpha = act_lookup(1'b0, longint'($signed(s_tdata[25:10])));
					vp = clip16(h + longint'($signed(s_tdata[41:26])));
					v = act_lookup(1'b1, vp);
					hn = clip16(rnd_shift(alpha * h + ((longint'(1) << FB) - alpha) * v,
						FB));
					if (idx < agrs_pkg::DEPTH) hidden_mem[idx] = hn[15:0];
					sg = act_lookup(1'b0, hn);
					o = (longint'(hn * hn * sg) + (longint'(1) << (3 * FB - 1)))
						>> (3 * FB);
					if (o > 32767) o = 32767;
					exp_w.hidden_new = hn[15:0];
					exp_w.out_value = o[14:0];
					exp_w.value_pre = vp[15:0];
					exp_w.gate_alpha = alpha > 8191 ? 13'd8191 : alpha[12:0];
					cell_q.push_back(exp_w);
				end
			end
			if (m_tvalid && m_tready) begin
				got.hidden_new = m_tdata[15:0];
				got.out_value = m_tdata[30:16];
				got.value_pre = m_tdata[46:31];
				got.gate_alpha = m_tdata[59:47];
				if (cell_q.size() == 0) begin
					$display("%0t: unexpected word, actual %h", $time, m_tdata);
					errors++;
				end else begin
					exp_w = cell_q.pop_front();
					if (got.hidden_new !== exp_w.hidden_new) begin
						$display("%0t: hidden_new expected %0d actual %0d", $time,
							exp_w.hidden_new, got.hidden_new);
						errors++;
					end
					if (got.out_value !== exp_w.out_value) begin
						$display("%0t: out_value expected %0d actual %0d", $time,
							exp_w.out_value, got.out_value);
						errors++;
					end
					if (got.value_pre !== exp_w.value_pre) begin
						$display("%0t: value_pre expected %0d actual %0d", $time,
							exp_w.value_pre, got.value_pre);
						errors++;
					end
					if (got.gate_alpha !== exp_w.gate_alpha) begin
						$display("%0t: gate_alpha expected %0d actual %0d", $time,
							exp_w.gate_alpha, got.gate_alpha);
						errors++;
					end
				end
			end
		end
	end

endmodule

FILE: tb/tb_additive_gated_recurrence_step.sv
`timescale 1ns / 1ps
// Testbench top for the gated recurrence step: stimulus, stalls and final verdict.
module tb_additive_gated_recurrence_step;

	localparam logic [0:0] LD = agrs_pkg::REQ_LOAD;
	localparam logic [0:0] ST = agrs_pkg::REQ_STEP;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;  // unit_index, gate_pre, proj_in, init_value, zero pad
	logic        s_tuser = 1'b0;  // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;  // hidden_new, out_value, value_pre, gate_alpha, zero pad
	int          errors;
	int          pending;
	int          cyc = 0;
	bit          no_idle = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	additive_gated_recurrence_step dut (.*);

	agrs_step_checker checker_i (.*);

	always @(posedge clk) begin
		cyc <= cyc + 1;
		m_tready <= (cyc > 4000 && cyc < 5500) || $urandom_range(99) >= 18;
	end

	task automatic send_word(input logic kind, input logic [9:0] unit,
		input logic [15:0] gate, input logic [15:0] proj, input logic [15:0] init);
		while (!no_idle && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'b0, init, proj, gate, unit};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [15:0] g;
		logic [15:0] p;
		logic [9:0]  u;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// untouched units read as zero after reset
		send_word(ST, 10'd0, 16'h0000, 16'h0000, 16'h0000);
		send_word(ST, 10'h3FF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
		send_word(ST, 10'd5, 16'h8000, 16'h8000, 16'h0000);
		send_word(LD, 10'd1, 16'hFFFF, 16'hFFFF, 16'h7FFF);
		send_word(ST, 10'd1, 16'h8000, 16'h7FFF, 16'h0000);
		send_word(LD, 10'd2, 16'h0000, 16'h0000, 16'h8000);
		send_word(ST, 10'd2, 16'h7FFF, 16'h8000, 16'h0000);
		send_word(LD, 10'd3, 16'h0000, 16'h0000, 16'h7FFF);
		send_word(ST, 10'd3, 16'h7FFF, 16'h7FFF, 16'h0000);
		send_word(ST, 10'd3, 16'h8000, 16'h8001, 16'h0000);
		send_word(ST, 10'd3, 16'h0001, 16'hFFFF, 16'h0000);
		send_word(ST, 10'd4, 16'h1000, 16'h2000, 16'h0000);
		send_word(ST, 10'd4, 16'hF000, 16'hE000, 16'h0000);
		send_word(LD, 10'h3FF, 16'h0000, 16'h0000, 16'h4000);
		send_word(ST, 10'h3FF, 16'h0000, 16'h3000, 16'h0000);
		drain();
		for (int n = 0; n < 750; n++) begin
			no_idle = n >= 300 && n < 420;
			u = $urandom_range(3) == 0 ? 10'($urandom_range(7)) : 10'($urandom);
			case ($urandom_range(3))
				0: g = 16'($urandom);
				1: g = 16'($signed(16'($urandom_range(16383))) - 16'sd8192);
				2: g = $urandom_range(1) ? 16'h7FFF : 16'h8000;
				default: g = 16'($urandom_range(8191)) - 16'd4096;
			endcase
			p = $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(16383)) - 16'd8192;
			send_word($urandom_range(4) == 0 ? LD : ST, u, g, p, 16'($urandom));
			if (n == 500) drain();
		end
		no_idle = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#3ms;
		$display("status: fail");
		$finish;
	end

endmodule
